// ===== rtl/rcs_pkg.sv =====
// shared types, constants and a helper function for the regularized cross-spectrum block
// no dependencies
`timescale 1ns / 1ps
package rcs_pkg;

   localparam int NUM_W = 66;   // magnitude of a cross product sum
   localparam int DEN_W = 67;   // denominator and division remainder
   localparam int QUO_W = 31;   // quotient bits below the saturation bit
   localparam int IDX_W = 20;

   typedef enum logic [0:0] {
      REG_BETA_SQUARED = 1'b0,
      REG_CUTOFF_SQ    = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_NORMAL = 2'd0,
      ST_CUT    = 2'd1,
      ST_ZERO   = 2'd2,
      ST_SAT    = 2'd3
   } status_type;

   typedef struct packed {
      logic               neg;
      logic               sat;
      logic [DEN_W-1:0]   rem;
      logic [NUM_W-1:0]   mag;
      logic [QUO_W-1:0]   quo;
   } lane_type;

   typedef struct packed {
      logic               valid;
      logic               cut;
      logic               zero;
      logic [DEN_W-1:0]   den;
      logic [IDX_W-1:0]   plus_index;
      logic [IDX_W-1:0]   minus_index;
   } side_type;

   // v mod m for v below 2^9 by binary compare and subtract
   function automatic int reduce_mod(input logic [8:0] v, input int m);
      int r;
      r = int'(v);
      for (int j = 8; j >= 0; j--) begin
         if (r >= (m << j)) begin
            r = r - (m << j);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/rcs_req_if.sv =====
// request channel: spectral position and packed coefficients at +f and -f
// depends on nothing
`timescale 1ns / 1ps
interface rcs_req_if;
   logic               valid;
   logic               ready;
   logic signed [7:0]  freq_x;
   logic [6:0]         freq_y;
   logic signed [31:0] pos_re;
   logic signed [31:0] pos_im;
   logic signed [31:0] neg_re;
   logic signed [31:0] neg_im;

   modport source (output valid, freq_x, freq_y, pos_re, pos_im, neg_re, neg_im,
                   input ready);
   modport sink (input valid, freq_x, freq_y, pos_re, pos_im, neg_re, neg_im,
                 output ready);
endinterface

// ===== rtl/rcs_rsp_if.sv =====
// result channel: target indices, peak coefficient and status
// depends on nothing
`timescale 1ns / 1ps
interface rcs_rsp_if;
   logic               valid;
   logic               ready;
   logic [19:0]        plus_index;
   logic [19:0]        minus_index;
   logic signed [31:0] peak_re;
   logic signed [31:0] peak_im;
   logic [1:0]         status;

   modport source (output valid, plus_index, minus_index, peak_re, peak_im, status,
                   input ready);
   modport sink (input valid, plus_index, minus_index, peak_re, peak_im, status,
                 output ready);
endinterface

// ===== rtl/rcs_front.sv =====
// front pipeline: spectrum separation, products, sums, indices and saturation test
// depends on rcs_pkg
`timescale 1ns / 1ps
module rcs_front #(
   parameter int X_SIZE = 256,
   parameter int Y_SIZE = 256,
   parameter int ZOOM   = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               ce,
   input  logic               in_valid,
   input  logic signed [7:0]  freq_x,
   input  logic [6:0]         freq_y,
   input  logic signed [31:0] pos_re,
   input  logic signed [31:0] pos_im,
   input  logic signed [31:0] neg_re,
   input  logic signed [31:0] neg_im,
   input  logic [31:0]        beta_squared,
   input  logic [15:0]        cutoff_sq,
   output rcs_pkg::side_type  side_o,
   output rcs_pkg::lane_type  lane_re_o,
   output rcs_pkg::lane_type  lane_im_o
);
   localparam int BX = ZOOM * X_SIZE;
   localparam int BY = ZOOM * Y_SIZE;
   localparam int CX = 128 % BX;
   localparam int CY = 128 % BY;
   localparam int NUM_W = rcs_pkg::NUM_W;
   localparam int DEN_W = rcs_pkg::DEN_W;
   localparam int IDX_W = rcs_pkg::IDX_W;

   // stage 0
   logic               v0_ff;
   logic signed [7:0]  fx_ff;
   logic [6:0]         fy_ff;
   logic signed [31:0] pr_ff, pi_ff, nr_ff, ni_ff;

   // stage 1
   logic               v1_ff, v1_in;
   logic               cut1_ff, cut1_in;
   logic signed [32:0] r1_ff, i1_ff, r2_ff, i2_ff;
   logic signed [32:0] r1_in, i1_in, r2_in, i2_in;
   logic [IDX_W-1:0]   pidx1_ff, midx1_ff, pidx1_in, midx1_in;

   // stage 2
   logic               v2_ff, cut2_ff;
   logic [IDX_W-1:0]   pidx2_ff, midx2_ff;
   logic signed [65:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_r1_ff, p_i1_ff;

   // stage 3
   logic               v3_ff, cut3_ff;
   logic [IDX_W-1:0]   pidx3_ff, midx3_ff;
   logic signed [66:0] zr_in, zi_in;
   logic [DEN_W-1:0]   den_in, den3_ff;
   logic               nre_ff, nim_ff;
   logic [NUM_W-1:0]   mre_in, mim_in, mre_ff, mim_ff;

   // stage 4
   rcs_pkg::side_type  side_ff;
   rcs_pkg::lane_type  lre_ff, lim_ff, lre_in, lim_in;

   int                 xp, xm, yp, ym;
   logic [15:0]        rad_sq;
   logic [63:0]        pidx_w, midx_w;

   // index wrap, cutoff and spectrum separation
   always_comb begin
      xp = rcs_pkg::reduce_mod(9'(int'(fx_ff) + 128), BX);
      xm = rcs_pkg::reduce_mod(9'(128 - int'(fx_ff)), BX);
      yp = rcs_pkg::reduce_mod(9'(int'(fy_ff) + 128), BY);
      ym = rcs_pkg::reduce_mod(9'(128 - int'(fy_ff)), BY);
      xp = (xp >= CX) ? xp - CX : xp + BX - CX;
      xm = (xm >= CX) ? xm - CX : xm + BX - CX;
      yp = (yp >= CY) ? yp - CY : yp + BY - CY;
      ym = (ym >= CY) ? ym - CY : ym + BY - CY;
      pidx_w = 64'(longint'(yp) * longint'(BX) + longint'(xp));
      midx_w = 64'(longint'(ym) * longint'(BX) + longint'(xm));
      pidx1_in = pidx_w[IDX_W-1:0];
      midx1_in = midx_w[IDX_W-1:0];
      rad_sq = 16'(int'(fx_ff) * int'(fx_ff) + int'(fy_ff) * int'(fy_ff));
      cut1_in = rad_sq < cutoff_sq;
      v1_in = v0_ff;
      r1_in = 33'(pr_ff) + 33'(nr_ff);
      i1_in = 33'(pi_ff) - 33'(ni_ff);
      r2_in = 33'(pi_ff) + 33'(ni_ff);
      i2_in = 33'(nr_ff) - 33'(pr_ff);
   end

   // sums and magnitudes
   always_comb begin
      zr_in  = 67'(p_rr_ff) + 67'(p_ii_ff);
      zi_in  = 67'(p_ri_ff) - 67'(p_ir_ff);
      den_in = DEN_W'(p_r1_ff) + DEN_W'(p_i1_ff) + DEN_W'({beta_squared, 16'h0000});
      mre_in = zr_in[66] ? NUM_W'(-zr_in) : NUM_W'(zr_in);
      mim_in = zi_in[66] ? NUM_W'(-zi_in) : NUM_W'(zi_in);
   end

   // saturation test and first remainder
   always_comb begin
      lre_in.neg = nre_ff;
      lre_in.mag = mre_ff;
      lre_in.rem = DEN_W'(mre_ff[NUM_W-1:15]);
      lre_in.sat = DEN_W'(mre_ff[NUM_W-1:15]) >= den3_ff;
      lre_in.quo = '0;
      lim_in.neg = nim_ff;
      lim_in.mag = mim_ff;
      lim_in.rem = DEN_W'(mim_ff[NUM_W-1:15]);
      lim_in.sat = DEN_W'(mim_ff[NUM_W-1:15]) >= den3_ff;
      lim_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ce) begin
         v0_ff <= in_valid;
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (ce) begin
         side_ff.valid <= v3_ff;
      end
      if (ce) begin
         fx_ff    <= freq_x;
         fy_ff    <= freq_y;
         pr_ff    <= pos_re;
         pi_ff    <= pos_im;
         nr_ff    <= neg_re;
         ni_ff    <= neg_im;
         cut1_ff  <= cut1_in;
         r1_ff    <= r1_in;
         i1_ff    <= i1_in;
         r2_ff    <= r2_in;
         i2_ff    <= i2_in;
         pidx1_ff <= pidx1_in;
         midx1_ff <= midx1_in;
         cut2_ff  <= cut1_ff;
         pidx2_ff <= pidx1_ff;
         midx2_ff <= midx1_ff;
         p_rr_ff  <= 66'(r1_ff) * 66'(r2_ff);
         p_ii_ff  <= 66'(i1_ff) * 66'(i2_ff);
         p_ri_ff  <= 66'(r1_ff) * 66'(i2_ff);
         p_ir_ff  <= 66'(i1_ff) * 66'(r2_ff);
         p_r1_ff  <= 66'(r1_ff) * 66'(r1_ff);
         p_i1_ff  <= 66'(i1_ff) * 66'(i1_ff);
         cut3_ff  <= cut2_ff;
         pidx3_ff <= pidx2_ff;
         midx3_ff <= midx2_ff;
         den3_ff  <= den_in;
         nre_ff   <= zr_in[66];
         nim_ff   <= zi_in[66];
         mre_ff   <= mre_in;
         mim_ff   <= mim_in;
         side_ff.cut         <= cut3_ff;
         side_ff.zero        <= den3_ff == '0;
         side_ff.den         <= den3_ff;
         side_ff.plus_index  <= pidx3_ff;
         side_ff.minus_index <= midx3_ff;
         lre_ff   <= lre_in;
         lim_ff   <= lim_in;
      end
   end

   assign side_o    = side_ff;
   assign lane_re_o = lre_ff;
   assign lane_im_o = lim_ff;
endmodule

// ===== rtl/rcs_cell.sv =====
// one divider cell: resolves one quotient bit for the real and imaginary lanes
// depends on rcs_pkg
`timescale 1ns / 1ps
module rcs_cell #(
   parameter int K = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  rcs_pkg::side_type side_i,
   input  rcs_pkg::lane_type lane_i [0:1],
   output rcs_pkg::side_type side_o,
   output rcs_pkg::lane_type lane_o [0:1]
);
   localparam int DEN_W = rcs_pkg::DEN_W;

   rcs_pkg::side_type side_ff;
   rcs_pkg::lane_type lane_ff [0:1];
   rcs_pkg::lane_type lane_in [0:1];
   logic [1:0]        nbit;
   logic [DEN_W:0]    trial [0:1];

   // numerator bit K; the low 16 bits of the scaled numerator are zero
   generate
      if (K >= 16) begin : g_bit
         assign nbit = {lane_i[1].mag[K-16], lane_i[0].mag[K-16]};
      end else begin : g_zero
         assign nbit = 2'b00;
      end
   endgenerate

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         trial[l] = {lane_i[l].rem, nbit[l]};
         lane_in[l] = lane_i[l];
         if (trial[l] >= {1'b0, side_i.den}) begin
            lane_in[l].rem = DEN_W'(trial[l] - {1'b0, side_i.den});
            lane_in[l].quo = {lane_i[l].quo[rcs_pkg::QUO_W-2:0], 1'b1};
         end else begin
            lane_in[l].rem = trial[l][DEN_W-1:0];
            lane_in[l].quo = {lane_i[l].quo[rcs_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (ce) begin
         side_ff.valid <= side_i.valid;
      end
      if (ce) begin
         side_ff.cut         <= side_i.cut;
         side_ff.zero        <= side_i.zero;
         side_ff.den         <= side_i.den;
         side_ff.plus_index  <= side_i.plus_index;
         side_ff.minus_index <= side_i.minus_index;
         lane_ff[0]          <= lane_in[0];
         lane_ff[1]          <= lane_in[1];
      end
   end

   assign side_o    = side_ff;
   assign lane_o[0] = lane_ff[0];
   assign lane_o[1] = lane_ff[1];
endmodule

// ===== rtl/regularized_cross_spectrum_top.sv =====
// top level of the regularized cross-spectrum block: registers, front, divider cells, output
// depends on rcs_pkg, rcs_req_if, rcs_rsp_if, rcs_front, rcs_cell
//
// channel  direction  payload
// req      in         freq_x, freq_y, pos_re, pos_im, neg_re, neg_im
// rsp      out        plus_index, minus_index, peak_re, peak_im, status
// csr      in         csr_we, csr_index, csr_wdata (beta_squared, cutoff_sq)
//
// one request per cycle unless rsp stalls; 5 front stages, 31 divider cells, output register
// the chain of divider cells, one quotient bit per cell, sets the latency
// synchronous reset clears valid flags and the csr registers; no clearing pass
// a stalled response freezes the whole pipeline; req.ready is low only then
`timescale 1ns / 1ps
module regularized_cross_spectrum_top #(
   parameter int X_SIZE = 256,
   parameter int Y_SIZE = 256,
   parameter int ZOOM   = 4
) (
   input  logic        clock,
   input  logic        reset,
   rcs_req_if.sink     req,
   rcs_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int NCELL = rcs_pkg::QUO_W;

   logic [31:0]        beta_ff;
   logic [15:0]        cutoff_ff;
   logic               ce;
   logic               out_valid_ff;
   logic [19:0]        pidx_ff, midx_ff;
   logic signed [31:0] re_ff, im_ff, re_in, im_in;
   rcs_pkg::status_type status_ff, status_in;

   rcs_pkg::side_type  side_w [0:NCELL];
   rcs_pkg::lane_type  lane_w [0:NCELL][0:1];
   rcs_pkg::side_type  sfin;
   rcs_pkg::lane_type  lfin [0:1];
   logic [31:0]        mag [0:1];
   logic signed [31:0] val [0:1];

   assign ce        = !out_valid_ff || rsp.ready;
   assign req.ready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff   <= '0;
         cutoff_ff <= '0;
      end else if (csr_we) begin
         case (rcs_pkg::reg_index_type'(csr_index))
            rcs_pkg::REG_BETA_SQUARED: beta_ff   <= csr_wdata;
            rcs_pkg::REG_CUTOFF_SQ:    cutoff_ff <= csr_wdata[15:0];
            default:                   beta_ff   <= beta_ff;
         endcase
      end
   end

   rcs_front #(
      .X_SIZE(X_SIZE),
      .Y_SIZE(Y_SIZE),
      .ZOOM(ZOOM)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .ce(ce),
      .in_valid(req.valid),
      .freq_x(req.freq_x),
      .freq_y(req.freq_y),
      .pos_re(req.pos_re),
      .pos_im(req.pos_im),
      .neg_re(req.neg_re),
      .neg_im(req.neg_im),
      .beta_squared(beta_ff),
      .cutoff_sq(cutoff_ff),
      .side_o(side_w[0]),
      .lane_re_o(lane_w[0][0]),
      .lane_im_o(lane_w[0][1])
   );

   generate
      for (genvar g = 0; g < NCELL; g++) begin : g_cell
         rcs_cell #(
            .K(NCELL - 1 - g)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .ce(ce),
            .side_i(side_w[g]),
            .lane_i(lane_w[g]),
            .side_o(side_w[g+1]),
            .lane_o(lane_w[g+1])
         );
      end
   endgenerate

   assign sfin    = side_w[NCELL];
   assign lfin[0] = lane_w[NCELL][0];
   assign lfin[1] = lane_w[NCELL][1];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag[l] = lfin[l].sat ? 32'h7FFF_FFFF : {1'b0, lfin[l].quo};
         val[l] = lfin[l].neg ? -$signed(mag[l]) : $signed(mag[l]);
      end
      if (sfin.cut) begin
         status_in = rcs_pkg::ST_CUT;
         re_in = '0;
         im_in = '0;
      end else if (sfin.zero) begin
         status_in = rcs_pkg::ST_ZERO;
         re_in = '0;
         im_in = '0;
      end else begin
         status_in = (lfin[0].sat || lfin[1].sat) ? rcs_pkg::ST_SAT : rcs_pkg::ST_NORMAL;
         re_in = val[0];
         im_in = val[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ce) begin
         out_valid_ff <= sfin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pidx_ff   <= sfin.plus_index;
         midx_ff   <= sfin.minus_index;
         re_ff     <= re_in;
         im_ff     <= im_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.plus_index  = pidx_ff;
   assign rsp.minus_index = midx_ff;
   assign rsp.peak_re     = re_ff;
   assign rsp.peak_im     = im_ff;
   assign rsp.status      = status_ff;
endmodule

// ===== bench/regularized_cross_spectrum_top_test.sv =====
// testbench for regularized_cross_spectrum_top: a bit-exact predictor checks every response
// depends on rcs_pkg, rcs_req_if, rcs_rsp_if and the top level under rtl
`timescale 1ns / 1ps
module regularized_cross_spectrum_top_test;

   localparam int BX         = 4 * 256;
   localparam int BY         = 4 * 256;
   localparam int LATENCY    = 37;
   localparam int CYCLE_STOP = 1500000;

   typedef struct {
      logic signed [7:0]  freq_x;
      logic [6:0]         freq_y;
      logic signed [31:0] pos_re;
      logic signed [31:0] pos_im;
      logic signed [31:0] neg_re;
      logic signed [31:0] neg_im;
   } request_type;

   typedef struct {
      logic [19:0]         plus_index;
      logic [19:0]         minus_index;
      logic signed [31:0]  peak_re;
      logic signed [31:0]  peak_im;
      rcs_pkg::status_type status;
   } peak_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = rcs_pkg::REG_BETA_SQUARED;
   logic [31:0] csr_wdata = '0;

   rcs_req_if req ();
   rcs_rsp_if rsp ();

   regularized_cross_spectrum_top u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [31:0] beta_squared = '0;
   logic [15:0] cutoff_sq = '0;
   peak_type    expected_peaks[$];
   int          failures = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.freq_x = '0;
      req.freq_y = '0;
      req.pos_re = '0;
      req.pos_im = '0;
      req.neg_re = '0;
      req.neg_im = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_STOP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int wrap_mod(input int v, input int m);
      return ((v % m) + m) % m;
   endfunction

   function automatic logic signed [31:0] scaled_quotient(input logic signed [127:0] num,
                                                          input logic [127:0] den,
                                                          inout logic sat);
      logic [127:0] mag;
      logic [127:0] quo;
      mag = num < 0 ? -num : num;
      mag = mag << 16;
      quo = mag / den;
      if (quo > 128'h7fffffff) begin
         sat = 1'b1;
         quo = 128'h7fffffff;
      end
      return num < 0 ? -quo[31:0] : quo[31:0];
   endfunction

   function automatic peak_type predict_peak(input request_type r);
      peak_type p;
      int x;
      int y;
      logic signed [127:0] r1, i1, r2, i2, zr, zi;
      logic [127:0] den;
      logic sat;
      x = int'(r.freq_x);
      y = int'(r.freq_y);
      p.plus_index = 20'(wrap_mod(y, BY) * BX + wrap_mod(x, BX));
      p.minus_index = 20'(wrap_mod(-y, BY) * BX + wrap_mod(-x, BX));
      p.peak_re = '0;
      p.peak_im = '0;
      p.status = rcs_pkg::ST_NORMAL;
      if (x * x + y * y < int'(cutoff_sq)) begin
         p.status = rcs_pkg::ST_CUT;
      end else begin
         r1 = r.pos_re + r.neg_re;
         i1 = r.pos_im - r.neg_im;
         r2 = r.pos_im + r.neg_im;
         i2 = r.neg_re - r.pos_re;
         zr = r1 * r2 + i1 * i2;
         zi = r1 * i2 - i1 * r2;
         den = r1 * r1 + i1 * i1 + ({96'd0, beta_squared} << 16);
         if (den == 0) begin
            p.status = rcs_pkg::ST_ZERO;
         end else begin
            sat = 1'b0;
            p.peak_re = scaled_quotient(zr, den, sat);
            p.peak_im = scaled_quotient(zi, den, sat);
            if (sat) p.status = rcs_pkg::ST_SAT;
         end
      end
      return p;
   endfunction

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      peak_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_peaks.size() == 0) begin
            $display("%0t unexpected response plus_index %h", $time, rsp.plus_index);
            failures++;
         end else begin
            e = expected_peaks.pop_front();
            if (rsp.plus_index !== e.plus_index) begin
               $display("%0t plus_index expected %h actual %h", $time, e.plus_index,
                        rsp.plus_index);
               failures++;
            end
            if (rsp.minus_index !== e.minus_index) begin
               $display("%0t minus_index expected %h actual %h", $time, e.minus_index,
                        rsp.minus_index);
               failures++;
            end
            if (rsp.peak_re !== e.peak_re) begin
               $display("%0t peak_re expected %h actual %h", $time, e.peak_re, rsp.peak_re);
               failures++;
            end
            if (rsp.peak_im !== e.peak_im) begin
               $display("%0t peak_im expected %h actual %h", $time, e.peak_im, rsp.peak_im);
               failures++;
            end
            if (rsp.status !== e.status) begin
               $display("%0t status expected %0d actual %0d", $time, e.status, rsp.status);
               failures++;
            end
         end
      end
   end

   task automatic send_request(input request_type r);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req.valid <= 1'b1;
      req.freq_x <= r.freq_x;
      req.freq_y <= r.freq_y;
      req.pos_re <= r.pos_re;
      req.pos_im <= r.pos_im;
      req.neg_re <= r.neg_re;
      req.neg_im <= r.neg_im;
      do @(posedge clock); while (!req.ready);
      expected_peaks.push_back(predict_peak(r));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req.valid <= 1'b0;
      while (expected_peaks.size() != 0) @(negedge clock);
      repeat (LATENCY + 3) @(negedge clock);
   endtask

   task automatic write_csr(input rcs_pkg::reg_index_type idx, input logic [31:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == rcs_pkg::REG_BETA_SQUARED) beta_squared = value;
      else cutoff_sq = value[15:0];
   endtask

   function automatic request_type make_request(input int sx, input int sy, input int pr,
                                                input int pi, input int nr, input int ni);
      request_type r;
      r.freq_x = sx[7:0];
      r.freq_y = sy[6:0];
      r.pos_re = pr;
      r.pos_im = pi;
      r.neg_re = nr;
      r.neg_im = ni;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int kind;
      r = make_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      kind = $urandom_range(9);
      case (kind)
         0: begin
            r.neg_re = -r.pos_re;
            r.neg_im = r.pos_im;
         end
         1: begin
            r.pos_re = $urandom_range(3);
            r.neg_re = -$urandom_range(3);
         end
         2, 3: begin
            r.pos_re = $signed($urandom_range(2 ** 20)) - 2 ** 19;
            r.pos_im = $signed($urandom_range(2 ** 20)) - 2 ** 19;
            r.neg_re = $signed($urandom_range(2 ** 20)) - 2 ** 19;
            r.neg_im = $signed($urandom_range(2 ** 20)) - 2 ** 19;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic test_directed();
      send_request(make_request(0, 0, 0, 0, 0, 0));
      send_request(make_request(-128, 127, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff));
      send_request(make_request(127, 0, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h80000000));
      send_request(make_request(-128, 0, 32'h80000000, 32'h7fffffff,
                                32'h7fffffff, 32'h80000000));
      send_request(make_request(0, 127, 32'h7fffffff, 32'h80000000,
                                32'h80000000, 32'h7fffffff));
      send_request(make_request(5, 3, 32'h10000, 0, 0, 0));
      send_request(make_request(-7, 9, 32'h10000, 32'h20000, 32'h30000, 32'h40000));
      send_request(make_request(1, 1, 1, 32'h40000000, 0, 32'h40000000));
      send_request(make_request(2, 2, 123, 456, -123, 456));
      send_request(make_request(-1, 1, -1, -1, -1, -1));
      send_request(make_request(3, 4, 32'h00018000, 32'hffff0000, 32'h00008000, 32'h7f000000));
      write_csr(rcs_pkg::REG_CUTOFF_SQ, 32'd32768);
      send_request(make_request(-128, 127, 32'h10000, 0, 0, 0));
      send_request(make_request(0, 0, 32'h10000, 0, 0, 0));
      write_csr(rcs_pkg::REG_CUTOFF_SQ, 32'd25);
      send_request(make_request(3, 4, 32'h10000, 32'h20000, 0, 0));
      send_request(make_request(4, 2, 32'h10000, 32'h20000, 0, 0));
      send_request(make_request(-4, 3, 32'h10000, 32'h20000, 0, 0));
      write_csr(rcs_pkg::REG_BETA_SQUARED, 32'hffffffff);
      send_request(make_request(10, 10, 0, 0, 0, 0));
      send_request(make_request(10, 10, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
      write_csr(rcs_pkg::REG_BETA_SQUARED, 32'h00000001);
      send_request(make_request(10, 10, 0, 0, 0, 0));
      send_request(make_request(10, 10, 0, 32'h7fffffff, 0, 32'h7fffffff));
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int n = 0; n < count; n++) begin
         send_request(random_request());
         if (n == count / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 71;
      test_directed();
      write_csr(rcs_pkg::REG_BETA_SQUARED, 32'd0);
      write_csr(rcs_pkg::REG_CUTOFF_SQ, 32'd0);
      test_random(640, 23, 71);
      write_csr(rcs_pkg::REG_BETA_SQUARED, 32'h00000100);
      write_csr(rcs_pkg::REG_CUTOFF_SQ, 32'd400);
      test_random(640, 71, 23);
      write_csr(rcs_pkg::REG_BETA_SQUARED, 32'($urandom));
      write_csr(rcs_pkg::REG_CUTOFF_SQ, 32'h0000ffff);
      test_random(100, 0, 0);
      write_csr(rcs_pkg::REG_CUTOFF_SQ, 32'($urandom_range(2000)));
      test_random(520, 0, 0);
      wait_drained();
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
